>>> hdl/pnf_pkg.sv
package pnf_pkg;

  localparam int TABLE_SIZE  = 256;
  localparam int IDX_W       = $clog2(TABLE_SIZE);
  localparam int MAX_OCTAVES = 8;
  localparam int OCT_W       = $clog2(MAX_OCTAVES);
  localparam int FRAC_BITS   = 16;
  localparam int COORD_W     = 32;
  localparam int POS_W       = FRAC_BITS + IDX_W;
  localparam int OCT_STEP    = 23;
  localparam int OUT_W       = 19;
  localparam int VAL_W       = 24;
  localparam int SUM_W       = 26;
  localparam int FADE_W      = FRAC_BITS + 1;
  localparam int Q_W         = FRAC_BITS + 4;
  localparam int CFG_DATA_W  = 4;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_EVAL    = 1'b1;
  localparam logic CFG_MODE    = 1'b0;
  localparam logic CFG_OCTAVES = 1'b1;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_OFS0,
    ST_OFS1,
    ST_COORD,
    ST_H0,
    ST_H1,
    ST_H2,
    ST_H3,
    ST_H4,
    ST_H5,
    ST_H6,
    ST_H7,
    ST_L1,
    ST_L2,
    ST_L3,
    ST_ACC,
    ST_DONE
  } state_t;

endpackage

>>> hdl/pnf_ram.sv
module pnf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> hdl/perlin_noise_3d_fractal.sv
// Per octave: offset reads (normalized mode only), coordinate step, hash reads, lerp steps, accumulate.
// A finished result waits in ST_DONE until the output is free; a load only writes the permutation RAM.
// Speed is bound by the two read ports of the permutation RAM: 17 dependent reads per octave (14 raw).
// A one-entry input buffer takes the next request while the current one is at work.
// Reset (synchronous, rst_n low): table reads as identity, normalized mode on, one octave.
module perlin_noise_3d_fractal (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_action,
  input  logic [pnf_pkg::IDX_W-1:0]        in_table_index,
  input  logic [pnf_pkg::IDX_W-1:0]        in_table_value,
  input  logic signed [pnf_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [pnf_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [pnf_pkg::COORD_W-1:0] in_coord_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [pnf_pkg::OUT_W-1:0] out_noise_value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [pnf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import pnf_pkg::*;

  function automatic val_t blend(input logic [FADE_W-1:0] t, input val_t a, input val_t b);
    logic signed [VAL_W:0]          d;
    logic signed [VAL_W+FADE_W+1:0] p;
    d = {b[VAL_W-1], b} - {a[VAL_W-1], a};
    p = d * $signed({1'b0, t});
    return a + val_t'(p >>> FRAC_BITS);
  endfunction

  function automatic val_t grad(input logic [3:0] h, input val_t x, input val_t y, input val_t z);
    val_t u;
    val_t v;
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  state_t state_r, state_nxt;

  logic mode_r;
  logic [CFG_DATA_W-1:0] octaves_r;

  logic             pend_vld_r;
  logic             pend_act_r;
  idx_t             pend_idx_r;
  idx_t             pend_val_r;
  logic [POS_W-1:0] pend_c_r [3];

  logic [POS_W-1:0] c_r [3];
  logic             run_norm_r;
  logic [OCT_W-1:0] oct_r;
  logic [OCT_W-1:0] last_oct_r;
  idx_t             ox_r, oy_r;
  idx_t             xi_r, yi_r, zi_r;
  logic [FRAC_BITS-1:0] frac_r [3];
  idx_t             b_r, aa_r, ab_r, ba_r, bb_r;
  logic [3:0]       h_r [8];
  logic [FRAC_BITS-1:0] t1_r [3];
  logic [FRAC_BITS-1:0] t2_r [3];
  logic [Q_W-1:0]   p_r [3];
  logic [FRAC_BITS-1:0] t3_r [3];
  logic [Q_W-1:0]   inner_r [3];
  logic [FADE_W-1:0] fade_r [3];
  val_t             e_r [4];
  val_t             f_r [2];
  val_t             nz_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [OUT_W-1:0] res_r;
  logic             out_vld_r;
  logic signed [OUT_W-1:0] out_val_r;

  logic [TABLE_SIZE-1:0] tvld_r;
  logic va_r, vb_r;
  idx_t qa_r, qb_r;
  idx_t ram_a, ram_b, tq_a, tq_b;
  idx_t rd_a, rd_b;

  logic accept, take, ram_we, out_free, last_oct;
  idx_t base;
  logic [CFG_DATA_W-1:0] oct_clamp;
  val_t g [8];
  val_t fx [3];
  val_t fx1 [3];
  logic [POS_W-1:0] sh [3];
  idx_t oz_sel;
  val_t nz_sh;
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [SUM_W-1:0] res_full;

  assign in_stall  = pend_vld_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_noise_value = out_val_r;

  assign accept   = in_valid && !pend_vld_r;
  assign take     = (state_r == ST_IDLE) && pend_vld_r;
  assign ram_we   = take && (pend_act_r == ACT_LOAD);
  assign out_free = !out_vld_r || !out_stall;
  assign last_oct = (oct_r == last_oct_r);
  assign base     = idx_t'({{(IDX_W-OCT_W){1'b0}}, oct_r} * idx_t'(OCT_STEP));

  assign tq_a = va_r ? ram_a : qa_r;
  assign tq_b = vb_r ? ram_b : qb_r;

  assign oct_clamp = (octaves_r == '0) ? CFG_DATA_W'(1) :
                     ((octaves_r > CFG_DATA_W'(MAX_OCTAVES)) ?
                      CFG_DATA_W'(MAX_OCTAVES) : octaves_r);

  pnf_ram #(
    .WIDTH(IDX_W),
    .DEPTH(TABLE_SIZE)
  ) u_perm_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (pend_idx_r),
    .wdata   (pend_val_r),
    .raddr_a (rd_a),
    .rdata_a (ram_a),
    .raddr_b (rd_b),
    .rdata_b (ram_b)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take && pend_act_r == ACT_EVAL) begin
          state_nxt = mode_r ? ST_OFS0 : ST_COORD;
        end
      end
      ST_OFS0:  state_nxt = ST_OFS1;
      ST_OFS1:  state_nxt = ST_COORD;
      ST_COORD: state_nxt = ST_H0;
      ST_H0:    state_nxt = ST_H1;
      ST_H1:    state_nxt = ST_H2;
      ST_H2:    state_nxt = ST_H3;
      ST_H3:    state_nxt = ST_H4;
      ST_H4:    state_nxt = ST_H5;
      ST_H5:    state_nxt = ST_H6;
      ST_H6:    state_nxt = ST_H7;
      ST_H7:    state_nxt = ST_L1;
      ST_L1:    state_nxt = ST_L2;
      ST_L2:    state_nxt = ST_L3;
      ST_L3:    state_nxt = ST_ACC;
      ST_ACC:   state_nxt = last_oct ? ST_DONE : ST_OFS0;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_a = '0;
    rd_b = '0;
    unique case (state_r)
      ST_OFS0: begin
        rd_a = base;
        rd_b = base + idx_t'(1);
      end
      ST_OFS1: rd_a = base + idx_t'(2);
      ST_H0: begin
        rd_a = xi_r;
        rd_b = xi_r + idx_t'(1);
      end
      ST_H1: begin
        rd_a = tq_a + yi_r;
        rd_b = tq_a + yi_r + idx_t'(1);
      end
      ST_H2: begin
        rd_a = b_r;
        rd_b = b_r + idx_t'(1);
      end
      ST_H3: begin
        rd_a = aa_r;
        rd_b = tq_a + zi_r;
      end
      ST_H4: begin
        rd_a = ab_r;
        rd_b = bb_r;
      end
      ST_H5: begin
        rd_a = aa_r + idx_t'(1);
        rd_b = ba_r + idx_t'(1);
      end
      ST_H6: begin
        rd_a = ab_r + idx_t'(1);
        rd_b = bb_r + idx_t'(1);
      end
      default: begin
        rd_a = '0;
        rd_b = '0;
      end
    endcase
  end

  always_comb begin
    oz_sel = run_norm_r ? tq_a : '0;
    for (int k = 0; k < 3; k++) begin
      sh[k]  = c_r[k] << oct_r;
      fx[k]  = val_t'({1'b0, frac_r[k]});
      fx1[k] = fx[k] - val_t'(1 << FRAC_BITS);
    end
    g[0] = grad(h_r[0], fx[0],  fx[1],  fx[2]);
    g[1] = grad(h_r[1], fx1[0], fx[1],  fx[2]);
    g[2] = grad(h_r[2], fx[0],  fx1[1], fx[2]);
    g[3] = grad(h_r[3], fx1[0], fx1[1], fx[2]);
    g[4] = grad(h_r[4], fx[0],  fx[1],  fx1[2]);
    g[5] = grad(h_r[5], fx1[0], fx[1],  fx1[2]);
    g[6] = grad(h_r[6], fx[0],  fx1[1], fx1[2]);
    g[7] = grad(h_r[7], fx1[0], fx1[1], fx1[2]);
    nz_sh   = nz_r >>> oct_r;
    sum_nxt = sum_r + SUM_W'(nz_sh);
    if (run_norm_r) begin
      res_full = (sum_nxt >>> 1) + SUM_W'(1 << (FRAC_BITS - 1));
    end else begin
      res_full = SUM_W'(nz_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      mode_r     <= 1'b1;
      octaves_r  <= CFG_DATA_W'(1);
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      tvld_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MODE:    mode_r    <= cfg_data[0];
          CFG_OCTAVES: octaves_r <= cfg_data;
          default:     mode_r    <= mode_r;
        endcase
      end
      if (accept) begin
        pend_vld_r <= 1'b1;
      end else if (take) begin
        pend_vld_r <= 1'b0;
      end
      if (ram_we) begin
        tvld_r[pend_idx_r] <= 1'b1;
      end
      if (state_r == ST_DONE && out_free) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    va_r <= tvld_r[rd_a];
    vb_r <= tvld_r[rd_b];
    qa_r <= rd_a;
    qb_r <= rd_b;

    if (accept) begin
      pend_act_r  <= in_action;
      pend_idx_r  <= in_table_index;
      pend_val_r  <= in_table_value;
      pend_c_r[0] <= in_coord_x[POS_W-1:0];
      pend_c_r[1] <= in_coord_y[POS_W-1:0];
      pend_c_r[2] <= in_coord_z[POS_W-1:0];
    end

    for (int k = 0; k < 3; k++) begin
      t1_r[k]    <= frac_r[k];
      t2_r[k]    <= FRAC_BITS'((2*FRAC_BITS)'(frac_r[k] * frac_r[k]) >> FRAC_BITS);
      p_r[k]     <= Q_W'(((Q_W + FRAC_BITS)'(Q_W'(15 << FRAC_BITS) - Q_W'(6) * Q_W'(frac_r[k]))
                    * (Q_W + FRAC_BITS)'(frac_r[k])) >> FRAC_BITS);
      t3_r[k]    <= FRAC_BITS'((2*FRAC_BITS)'(t2_r[k] * t1_r[k]) >> FRAC_BITS);
      inner_r[k] <= Q_W'(10 << FRAC_BITS) - p_r[k];
      fade_r[k]  <= FADE_W'(((Q_W + FRAC_BITS)'(t3_r[k]) * (Q_W + FRAC_BITS)'(inner_r[k]))
                    >> FRAC_BITS);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          c_r        <= pend_c_r;
          run_norm_r <= mode_r;
          oct_r      <= '0;
          last_oct_r <= mode_r ? OCT_W'(oct_clamp - CFG_DATA_W'(1)) : '0;
          sum_r      <= '0;
          ox_r       <= '0;
          oy_r       <= '0;
        end
      end
      ST_OFS1: begin
        ox_r <= tq_a;
        oy_r <= tq_b;
      end
      ST_COORD: begin
        xi_r      <= sh[0][POS_W-1:FRAC_BITS] + ox_r;
        yi_r      <= sh[1][POS_W-1:FRAC_BITS] + oy_r;
        zi_r      <= sh[2][POS_W-1:FRAC_BITS] + oz_sel;
        frac_r[0] <= sh[0][FRAC_BITS-1:0];
        frac_r[1] <= sh[1][FRAC_BITS-1:0];
        frac_r[2] <= sh[2][FRAC_BITS-1:0];
      end
      ST_H1: b_r <= tq_b + yi_r;
      ST_H2: begin
        aa_r <= tq_a + zi_r;
        ab_r <= tq_b + zi_r;
      end
      ST_H3: begin
        ba_r <= tq_a + zi_r;
        bb_r <= tq_b + zi_r;
      end
      ST_H4: begin
        h_r[0] <= tq_a[3:0];
        h_r[1] <= tq_b[3:0];
      end
      ST_H5: begin
        h_r[2] <= tq_a[3:0];
        h_r[3] <= tq_b[3:0];
      end
      ST_H6: begin
        h_r[4] <= tq_a[3:0];
        h_r[5] <= tq_b[3:0];
      end
      ST_H7: begin
        h_r[6] <= tq_a[3:0];
        h_r[7] <= tq_b[3:0];
      end
      ST_L1: begin
        e_r[0] <= blend(fade_r[0], g[0], g[1]);
        e_r[1] <= blend(fade_r[0], g[2], g[3]);
        e_r[2] <= blend(fade_r[0], g[4], g[5]);
        e_r[3] <= blend(fade_r[0], g[6], g[7]);
      end
      ST_L2: begin
        f_r[0] <= blend(fade_r[1], e_r[0], e_r[1]);
        f_r[1] <= blend(fade_r[1], e_r[2], e_r[3]);
      end
      ST_L3: nz_r <= blend(fade_r[2], f_r[0], f_r[1]);
      ST_ACC: begin
        sum_r <= sum_nxt;
        oct_r <= oct_r + OCT_W'(1);
        if (res_full > SUM_W'((1 << (OUT_W - 1)) - 1)) begin
          res_r <= OUT_W'((1 << (OUT_W - 1)) - 1);
        end else if (res_full < -SUM_W'(1 << (OUT_W - 1))) begin
          res_r <= OUT_W'(1 << (OUT_W - 1));
        end else begin
          res_r <= OUT_W'(res_full);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_val_r <= res_r;
        end
      end
      default: begin
        b_r <= b_r;
      end
    endcase
  end

endmodule

>>> hdl/pnf_checker.sv
module pnf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [pnf_pkg::OUT_W-1:0] out_noise_value
);

  import pnf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_noise_value))
    else $error("stalled result changed");

  a_in_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input buffer did not hold the accepted request");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset left a request pending");

endmodule

bind perlin_noise_3d_fractal pnf_checker u_pnf_checker (.*);
